### src/cvdt_pkg.sv
// Shared types, constants and table functions for the civil date-time to
// epoch nanoseconds converter. No dependencies; every module in src uses it.
package cvdt_pkg;

    // Pipeline depth, request to result
    localparam int NSTAGE = 7;

    // Conversion constants
    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [29:0] FRAC_MAX_HI = 30'd854775807;  // fraction limit at top second
    localparam logic [29:0] FRAC_MIN_LO = 30'd145224192;  // fraction limit at bottom second
    localparam logic [4:0]  MAX_HOUR    = 5'd23;
    localparam logic [5:0]  MAX_MINUTE  = 6'd59;
    localparam logic [5:0]  LEAP_SECOND = 6'd60;
    localparam logic [6:0]  MAX_OFF_H   = 7'd23;
    localparam logic [6:0]  MAX_OFF_M   = 7'd59;

    // Divide-by-25 helpers: modular inverse test and floor reciprocal
    localparam logic [14:0] INV25_MOD15 = 15'd23593;
    localparam logic [14:0] DIV25_LIMIT = 15'd1310;
    localparam logic [15:0] RECIP25     = 16'd41944;  // ceil(2^20 / 25)

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_LEAP   = 3'd1,
        ST_DATE   = 3'd2,
        ST_TIME   = 3'd3,
        ST_OFFSET = 3'd4,
        ST_RANGE  = 3'd5
    } status_t;

    typedef struct packed {
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day_of_month;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [29:0]        fraction_ns;
        logic               has_offset;
        logic               offset_negative;
        logic [6:0]         offset_hours;
        logic [6:0]         offset_minutes;
    } req_t;

    typedef struct packed {
        logic signed [63:0] epoch_ns;
        status_t            status;
    } res_t;

    // Checked and decoded fields, leaving the check stage
    typedef struct packed {
        status_t            status;
        logic signed [16:0] yy;     // March-based year
        logic signed [14:0] q;      // floor(yy / 4)
        logic [14:0]        n;      // floor(yy / 4) + 10000, never negative
        logic [8:0]         doy;    // day of the March-based year
        logic [16:0]        tod;    // seconds into the day
        logic signed [17:0] off;    // signed offset in seconds
        logic [29:0]        frac;
    } chk_t;

    // Day count and second of day, leaving the day-count stages
    typedef struct packed {
        status_t            status;
        logic signed [25:0] days;
        logic signed [18:0] tsec;   // time of day minus offset, seconds
        logic [29:0]        frac;
    } day_sum_t;

    // Days in a month, given the leap flag of the calendar year
    function automatic logic [4:0] month_length(input logic leap, input logic [3:0] month);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // First day of each month counted from March 1
    function automatic logic [8:0] march_doy_base(input logic [3:0] month);
        logic [8:0] base;
        case (month)
            4'd3:    base = 9'd0;
            4'd4:    base = 9'd31;
            4'd5:    base = 9'd61;
            4'd6:    base = 9'd92;
            4'd7:    base = 9'd122;
            4'd8:    base = 9'd153;
            4'd9:    base = 9'd184;
            4'd10:   base = 9'd214;
            4'd11:   base = 9'd245;
            4'd12:   base = 9'd275;
            4'd1:    base = 9'd306;
            4'd2:    base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

### src/cvdt_check.sv
// First pipeline stage: field checks with status priority, and decode of the
// date and time into March-based year, day of year and seconds. Uses cvdt_pkg.
module cvdt_check (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  cvdt_pkg::req_t req,
    output cvdt_pkg::chk_t chk
);
    import cvdt_pkg::*;

    logic signed [15:0] yq;
    logic [14:0]        lp_n;
    logic [29:0]        lp_full;
    logic               div25;
    logic               leap;
    logic [4:0]         mlen;
    logic               bad_date;
    logic               bad_time;
    logic               bad_off;
    status_t            st_c;
    logic signed [16:0] yy_c;
    logic signed [16:0] yy_sh;
    logic [16:0]        offm;
    logic signed [17:0] off_mag;
    chk_t               chk_next;
    chk_t               chk_reg;

    // Leap year test: year/4 divisible by 25 via the modular inverse of 25
    always_comb
    begin
        yq      = req.year >>> 2;
        lp_n    = 15'(yq + 16'sd8200);
        lp_full = 30'(lp_n) * 30'(INV25_MOD15);
        div25   = lp_full[14:0] <= DIV25_LIMIT;
        leap    = (req.year[1:0] == 2'd0) && (!div25 || (req.year[3:0] == 4'd0));
        mlen    = month_length(leap, req.month);
    end

    // Classify the request in check order
    always_comb
    begin
        bad_date = (req.year == 16'sh8000) || (req.month == 4'd0) || (req.month > 4'd12) ||
                   (req.day_of_month == 5'd0) || (req.day_of_month > mlen);
        bad_time = (req.hour > MAX_HOUR) || (req.minute > MAX_MINUTE) ||
                   (req.second > MAX_MINUTE) || (req.fraction_ns >= NS_PER_SEC);
        bad_off  = req.has_offset &&
                   ((req.offset_hours > MAX_OFF_H) || (req.offset_minutes > MAX_OFF_M));
        if (req.second == LEAP_SECOND)
            st_c = ST_LEAP;
        else if (bad_date)
            st_c = ST_DATE;
        else if (bad_time)
            st_c = ST_TIME;
        else if (bad_off)
            st_c = ST_OFFSET;
        else
            st_c = ST_OK;
    end

    // Decode year, day of year, time of day and offset
    always_comb
    begin
        yy_c  = 17'(req.year) - ((req.month <= 4'd2) ? 17'sd1 : 17'sd0);
        yy_sh = yy_c >>> 2;
        chk_next.status = st_c;
        chk_next.yy   = yy_c;
        chk_next.q    = yy_sh[14:0];
        chk_next.n    = 15'(yy_sh + 17'sd10000);
        chk_next.doy  = march_doy_base(req.month) + 9'(req.day_of_month) - 9'd1;
        chk_next.tod  = 17'(req.hour) * 17'd3600 + 17'(req.minute) * 17'd60 +
                        17'(req.second);
        offm    = 17'(req.offset_hours) * 17'd3600 + 17'(req.offset_minutes) * 17'd60;
        off_mag = $signed({1'b0, offm});
        if (!req.has_offset)
            chk_next.off = 18'sd0;
        else if (req.offset_negative)
            chk_next.off = -off_mag;
        else
            chk_next.off = off_mag;
        chk_next.frac = req.fraction_ns;
    end

    // Hold on stall, advance on enable
    always_ff @(posedge clk)
    begin
        if (en)
            chk_reg <= chk_next;
    end

    assign chk = chk_reg;

    a_leap_first: assert property (@(posedge clk) disable iff (!rst_n)
        (en && (req.second == LEAP_SECOND)) |=> (chk.status == ST_LEAP))
        else $error("leap second request did not take leap status");

endmodule

### src/cvdt_days.sv
// Day-count stages: floor division by 100 through a reciprocal multiply, by
// 400 through a shift, then the days-from-civil sum. Uses cvdt_pkg.
module cvdt_days (
    input  logic              clk,
    input  logic [1:0]        en,
    input  cvdt_pkg::chk_t    chk,
    output cvdt_pkg::day_sum_t dsum
);
    import cvdt_pkg::*;

    logic [30:0]        c_full;
    logic [9:0]         c_next;
    logic [9:0]         c_reg;
    logic signed [25:0] base_next;
    logic signed [25:0] base_reg;
    logic signed [18:0] tsec_next;
    logic signed [18:0] tsec_reg;
    logic [29:0]        frac_reg;
    status_t            st_reg;
    logic signed [10:0] h;
    logic signed [25:0] h_ext;
    day_sum_t           dsum_next;
    day_sum_t           dsum_reg;

    // Stage two: floor(q / 25) + 400, year times 365 plus day of year
    always_comb
    begin
        c_full    = 31'(chk.n) * 31'(RECIP25);
        c_next    = c_full[29:20];
        base_next = 26'(chk.yy) * 26'sd365 + 26'(chk.q) + 26'($signed({1'b0, chk.doy})) -
                    26'sd719468;
        tsec_next = 19'($signed({1'b0, chk.tod})) - 19'(chk.off);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c_reg    <= c_next;
            base_reg <= base_next;
            tsec_reg <= tsec_next;
            frac_reg <= chk.frac;
            st_reg   <= chk.status;
        end
    end

    // Stage three: subtract the century days, add back every fourth century
    always_comb
    begin
        h     = $signed({1'b0, c_reg}) - 11'sd400;
        h_ext = 26'(h);
        dsum_next.days   = base_reg - h_ext + (h_ext >>> 2);
        dsum_next.tsec   = tsec_reg;
        dsum_next.frac   = frac_reg;
        dsum_next.status = st_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            dsum_reg <= dsum_next;
    end

    assign dsum = dsum_reg;

endmodule

### src/cvdt_scale.sv
// Scaling stages: days to seconds, range check against the signed 64-bit
// limits, and the nanosecond product split in two partial products. Uses cvdt_pkg.
module cvdt_scale (
    input  logic               clk,
    input  logic [3:0]         en,
    input  cvdt_pkg::day_sum_t dsum,
    output cvdt_pkg::res_t     res
);
    import cvdt_pkg::*;

    logic signed [42:0] dsec4_reg;
    logic signed [18:0] tsec4_reg;
    logic [29:0]        frac4_reg;
    status_t            st4_reg;
    logic signed [42:0] secs5_reg;
    logic [29:0]        frac5_reg;
    status_t            st5_reg;
    logic               in_range;
    status_t            st6_next;
    logic [50:0]        plo6_next;
    logic [42:0]        phi6_next;
    logic [50:0]        plo6_reg;
    logic [42:0]        phi6_reg;
    logic [29:0]        frac6_reg;
    status_t            st6_reg;
    logic [63:0]        sum7;
    res_t               res_next;
    res_t               res_reg;

    // Stage four: day count to seconds
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dsec4_reg <= 43'(dsum.days) * 43'sd86400;
            tsec4_reg <= dsum.tsec;
            frac4_reg <= dsum.frac;
            st4_reg   <= dsum.status;
        end
    end

    // Stage five: add time of day less offset
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            secs5_reg <= dsec4_reg + 43'(tsec4_reg);
            frac5_reg <= frac4_reg;
            st5_reg   <= st4_reg;
        end
    end

    // Stage six: range check, partial products of seconds times 1e9
    always_comb
    begin
        if (secs5_reg > 43'sd9223372036)
            in_range = 1'b0;
        else if (secs5_reg == 43'sd9223372036)
            in_range = frac5_reg <= FRAC_MAX_HI;
        else if (secs5_reg < -43'sd9223372037)
            in_range = 1'b0;
        else if (secs5_reg == -43'sd9223372037)
            in_range = frac5_reg >= FRAC_MIN_LO;
        else
            in_range = 1'b1;
        st6_next  = ((st5_reg == ST_OK) && !in_range) ? ST_RANGE : st5_reg;
        plo6_next = 51'(secs5_reg[20:0]) * 51'(NS_PER_SEC);
        phi6_next = 43'($signed(secs5_reg[42:21])) * 43'(NS_PER_SEC);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            plo6_reg  <= plo6_next;
            phi6_reg  <= phi6_next;
            frac6_reg <= frac5_reg;
            st6_reg   <= st6_next;
        end
    end

    // Stage seven: combine partial products, zero the time on any error
    always_comb
    begin
        sum7 = {phi6_reg, 21'd0} + 64'(plo6_reg) + 64'(frac6_reg);
        res_next.epoch_ns = (st6_reg == ST_OK) ? $signed(sum7) : 64'sd0;
        res_next.status   = st6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
            res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### src/civil_datetime_to_epoch_nanos_unit.sv
// Top level of the civil date-time to epoch nanoseconds converter: handshake,
// stage valid bits and stall control. Uses cvdt_pkg, cvdt_check, cvdt_days, cvdt_scale.
//
// Usage:
//   A request (req_valid/req_ready/req) carries a Gregorian date, a time of
//   day with nanosecond fraction and an optional UTC offset. Each request
//   gives exactly one result (res_valid/res_ready/res): signed nanoseconds
//   since 1970-01-01T00:00Z and a status code; the time is zero whenever the
//   status is not ok.
//   Requests pass through a seven-stage pipeline (check, two day-count
//   stages, four scaling stages), which takes one request per cycle while
//   the receiver does not stall.
//   Each stage holds its own valid bit. When res_ready is low the last stage
//   holds its result and earlier stages keep filling empty slots, so
//   req_ready stays high while any stage is free. req_ready follows
//   res_ready combinationally through the stage chain.
//   Reset (rst_n low, asynchronous) empties every stage; no result is shown
//   until a request enters after reset.
module civil_datetime_to_epoch_nanos_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cvdt_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output cvdt_pkg::res_t res
);
    import cvdt_pkg::*;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] adv;
    logic              in_acc;
    logic              out_acc;
    chk_t              chk;
    day_sum_t          dsum;

    // Each stage loads when it is empty or its contents move on
    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || res_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? req_valid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++)
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign req_ready = adv[0];
    assign res_valid = valid_reg[NSTAGE-1];
    assign in_acc    = req_valid && req_ready;
    assign out_acc   = res_valid && res_ready;

    cvdt_check u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (adv[0]),
        .req   (req),
        .chk   (chk)
    );

    cvdt_days u_days (
        .clk  (clk),
        .en   (adv[2:1]),
        .chk  (chk),
        .dsum (dsum)
    );

    cvdt_scale u_scale (
        .clk  (clk),
        .en   (adv[6:3]),
        .dsum (dsum),
        .res  (res)
    );

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> req_ready)
        else $error("request stalled while a stage was free");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
            ($countones(valid_reg) == $countones($past(valid_reg)) +
                                      int'($past(in_acc)) - int'($past(out_acc))))
        else $error("item lost or repeated in pipeline");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != ST_OK)) |-> (res.epoch_ns == 64'sd0))
        else $error("error result carries nonzero time");

endmodule

### tb/epoch_checker.sv
// Scoreboard for the civil date-time to epoch nanoseconds converter: predicts
// each result from the accepted request and compares it with what leaves.
// Depends on cvdt_pkg for the request and result types and the status codes.
module epoch_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  cvdt_pkg::req_t req,
    input  logic           res_valid,
    input  logic           res_ready,
    input  cvdt_pkg::res_t res,
    output int             mismatch_count,
    output int             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import cvdt_pkg::*;

    localparam longint NANOS_PER_SEC   = 64'sd1000000000;
    localparam longint SECS_PER_DAY    = 64'sd86400;
    localparam longint SECS_PER_HOUR   = 64'sd3600;
    localparam longint SECS_PER_MINUTE = 64'sd60;
    localparam longint DAYS_PER_ERA    = 64'sd146097;
    localparam longint EPOCH_DAY_SHIFT = 64'sd719468;  // days from 0000-03-01 to 1970-01-01
    localparam longint TOP_SECOND      = 64'sd9223372036;
    localparam longint TOP_FRACTION    = 64'sd854775807;
    localparam longint BOTTOM_SECOND   = -64'sd9223372037;
    localparam longint BOTTOM_FRACTION = 64'sd145224192;

    res_t pending_epochs[$];
    int   result_index;

    // Convert one request to the result the block must give
    function automatic res_t civil_to_epoch(input req_t r);
        res_t   o;
        longint y;
        longint m;
        longint d;
        longint yy;
        longint era;
        longint yoe;
        longint mp;
        longint doy;
        longint doe;
        longint days;
        longint secs;
        longint offs;
        longint frac;
        int     mlen;
        logic   leap;
        logic   in_range;
        o.epoch_ns = '0;
        o.status   = ST_OK;
        y    = longint'($signed(r.year));
        m    = longint'(r.month);
        d    = longint'(r.day_of_month);
        frac = longint'(r.fraction_ns);
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        case (r.month)
            4'd4, 4'd6, 4'd9, 4'd11: mlen = 30;
            4'd2:                    mlen = leap ? 29 : 28;
            default:                 mlen = 31;
        endcase
        if (r.second == 6'd60)
            o.status = ST_LEAP;
        else if (y == -32768 || m < 1 || m > 12 || d < 1 || d > mlen)
            o.status = ST_DATE;
        else if (r.hour > 23 || r.minute > 59 || r.second > 59 || frac >= NANOS_PER_SEC)
            o.status = ST_TIME;
        else if (r.has_offset && (r.offset_hours > 23 || r.offset_minutes > 59))
            o.status = ST_OFFSET;
        else
        begin
            // Count days in 400-year eras from a March-based year
            yy   = y - ((m <= 2) ? 1 : 0);
            era  = ((yy >= 0) ? yy : yy - 399) / 400;
            yoe  = yy - era * 400;
            mp   = (m > 2) ? m - 3 : m + 9;
            doy  = (153 * mp + 2) / 5 + d - 1;
            doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days = era * DAYS_PER_ERA + doe - EPOCH_DAY_SHIFT;
            secs = days * SECS_PER_DAY + longint'(r.hour) * SECS_PER_HOUR
                 + longint'(r.minute) * SECS_PER_MINUTE + longint'(r.second);
            // Subtract the offset; a minus sign adds it back
            if (r.has_offset)
            begin
                offs = (longint'(r.offset_hours) * 60 + longint'(r.offset_minutes))
                     * SECS_PER_MINUTE;
                secs = r.offset_negative ? secs + offs : secs - offs;
            end
            // Keep the result inside signed 64 bits
            if (secs > TOP_SECOND)
                in_range = 1'b0;
            else if (secs == TOP_SECOND)
                in_range = (frac <= TOP_FRACTION);
            else if (secs < BOTTOM_SECOND)
                in_range = 1'b0;
            else if (secs == BOTTOM_SECOND)
                in_range = (frac >= BOTTOM_FRACTION);
            else
                in_range = 1'b1;
            if (in_range)
                o.epoch_ns = secs * NANOS_PER_SEC + frac;
            else
                o.status = ST_RANGE;
        end
        return o;
    endfunction

    // Print one line for a mismatch and count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: result %0d: %s: got %0d, want %0d",
                 $realtime, result_index, what, got, want);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
        result_index   = 0;
    end

    // Compare results first, then queue the prediction for a new request
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (res_valid && res_ready)
            begin
                if (pending_epochs.size() == 0)
                    report_mismatch("result with no request outstanding",
                                    res.epoch_ns, 64'sd0);
                else
                begin
                    want = pending_epochs.pop_front();
                    if (res.status !== want.status)
                        report_mismatch("status", longint'(res.status),
                                        longint'(want.status));
                    if (res.epoch_ns !== want.epoch_ns)
                        report_mismatch("epoch_ns", res.epoch_ns, want.epoch_ns);
                end
                result_index++;
            end
            if (req_valid && req_ready)
                pending_epochs.push_back(civil_to_epoch(req));
            outstanding = pending_epochs.size();
        end
    end

endmodule

### tb/testbench.sv
// Top of the converter testbench: clock, reset, request and stall stimulus,
// and the verdict. Depends on cvdt_pkg, civil_datetime_to_epoch_nanos_unit and
// epoch_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cvdt_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int FRACTION_LIMIT = 999999999;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic res_valid;
    logic res_ready;
    res_t res;
    int   mismatch_total;
    int   outstanding;
    int   cycle_count = 0;
    int   calm_left = 0;

    civil_datetime_to_epoch_nanos_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    epoch_checker u_epoch_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .mismatch_count (mismatch_total),
        .outstanding    (outstanding)
    );

    always #(CLK_HALF) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 55)
            return 0;
        else if (pick < 85)
            return $urandom_range(3, 1);
        else if (pick < 97)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic req_t make_req(input int year, input int month, input int day,
                                      input int hour, input int minute, input int second,
                                      input int frac, input int has_off, input int neg,
                                      input int off_h, input int off_m);
        req_t r;
        r.year            = year[15:0];
        r.month           = month[3:0];
        r.day_of_month    = day[4:0];
        r.hour            = hour[4:0];
        r.minute          = minute[5:0];
        r.second          = second[5:0];
        r.fraction_ns     = frac[29:0];
        r.has_offset      = has_off[0];
        r.offset_negative = neg[0];
        r.offset_hours    = off_h[6:0];
        r.offset_minutes  = off_m[6:0];
        return r;
    endfunction

    // Random request: mostly well-formed dates, some near the range limits,
    // some with one field broken, the rest raw noise
    function automatic req_t random_request();
        req_t         r;
        logic [95:0]  noise;
        int           kind;
        int           year;
        kind = $urandom_range(99, 0);
        if (kind < 20)
        begin
            noise = {$urandom, $urandom, $urandom};
            return noise[87:0];
        end
        if (kind < 60)
            year = $urandom_range(2261, 1678);
        else if (kind < 72)
        begin
            case ($urandom_range(3, 0))
                0: year = 1677;
                1: year = 1678;
                2: year = 2261;
                default: year = 2262;
            endcase
        end
        else
            year = $urandom_range(65535, 1) - 32768;
        r = make_req(year, $urandom_range(12, 1),
                     ($urandom_range(9, 0) == 0) ? $urandom_range(31, 29) : $urandom_range(28, 1),
                     $urandom_range(23, 0), $urandom_range(59, 0), $urandom_range(59, 0),
                     $urandom_range(FRACTION_LIMIT, 0), $urandom_range(1, 0),
                     $urandom_range(1, 0), $urandom_range(23, 0), $urandom_range(59, 0));
        // Break one field
        if (kind >= 85)
        begin
            case ($urandom_range(7, 0))
                0: r.month = ($urandom_range(1, 0) == 0) ? 4'd0 : 4'($urandom_range(15, 13));
                1: r.day_of_month = ($urandom_range(1, 0) == 0) ? 5'd0 : 5'd31;
                2: r.hour = 5'($urandom_range(31, 24));
                3: r.minute = 6'($urandom_range(63, 60));
                4: r.second = 6'($urandom_range(63, 60));
                5: r.fraction_ns = 30'($urandom_range(1073741823, 1000000000));
                6: r.offset_hours = 7'($urandom_range(127, 24));
                default: r.offset_minutes = 7'($urandom_range(127, 60));
            endcase
        end
        return r;
    endfunction

    // Drive one request, honoring an idle gap first, and hold until accepted
    task automatic send_request(input req_t r);
        int gap;
        if (calm_left > 0)
        begin
            gap = 0;
            calm_left--;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(99, 0) < 2)
                calm_left = $urandom_range(200, 40);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       = r;
        req_valid = 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Hold off new requests until every result has come
    task automatic drain_results();
        @(negedge clk);
        req_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Stall the result side: random gaps, with stretches of no stall
    initial
    begin
        int free_left;
        int stall_left;
        int pick;
        free_left  = 0;
        stall_left = 0;
        res_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (free_left > 0)
            begin
                res_ready = 1'b1;
                free_left--;
            end
            else if (stall_left > 0)
            begin
                res_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                pick = $urandom_range(99, 0);
                if (pick < 4)
                begin
                    free_left = $urandom_range(300, 50);
                    res_ready = 1'b1;
                end
                else if (pick < 70)
                    res_ready = 1'b1;
                else
                begin
                    stall_left = idle_len();
                    res_ready  = 1'b0;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Epoch, the signed 64-bit range ends (also via offsets), just past them, extreme years
        send_request(make_req(1970, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2262, 4, 11, 23, 47, 16, 854775807, 0, 0, 0, 0));
        send_request(make_req(2262, 4, 11, 23, 47, 16, 854775808, 0, 0, 0, 0));
        send_request(make_req(1677, 9, 21, 0, 12, 43, 145224192, 0, 0, 0, 0));
        send_request(make_req(1677, 9, 21, 0, 12, 43, 145224191, 0, 0, 0, 0));
        send_request(make_req(2262, 4, 12, 0, 17, 16, 854775807, 1, 0, 0, 30));
        send_request(make_req(1677, 9, 20, 23, 42, 43, 145224192, 1, 1, 0, 30));
        send_request(make_req(-32767, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(32767, 12, 31, 23, 59, 59, FRACTION_LIMIT, 1, 1, 23, 59));
        // Date checks, leap years included
        send_request(make_req(-32768, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2000, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2000, 15, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2000, 2, 29, 12, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(1900, 2, 29, 12, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2023, 2, 29, 12, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2001, 4, 31, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2001, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Leap second wins over a bad date
        send_request(make_req(2016, 0, 31, 23, 59, 60, 0, 0, 0, 0, 0));
        // Time checks
        send_request(make_req(2010, 6, 15, 31, 0, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2010, 6, 15, 0, 63, 0, 0, 0, 0, 0, 0));
        send_request(make_req(2010, 6, 15, 0, 0, 63, 0, 0, 0, 0, 0));
        send_request(make_req(2010, 6, 15, 0, 0, 0, 1073741823, 1, 0, 99, 99));
        // Offset checks, ignored offset fields and a minus zero offset
        send_request(make_req(2010, 6, 15, 8, 30, 0, 0, 1, 0, 24, 0));
        send_request(make_req(2010, 6, 15, 8, 30, 0, 0, 1, 1, 0, 99));
        send_request(make_req(2010, 6, 15, 8, 30, 0, 0, 0, 1, 127, 127));
        send_request(make_req(2010, 6, 15, 8, 30, 0, 0, 1, 1, 0, 0));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            send_request(random_request());
        end

        // Wait for the last results, then let the pipeline settle
        drain_results();
        repeat (2 * NSTAGE) @(negedge clk);
        if (mismatch_total == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
